### design/stunx_pkg.sv
package stunx_pkg;

    // Field widths of the byte stream and of the result.
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned IP_W     = 32;
    localparam int unsigned PADLEN_W = 17;

    // Fixed header and protocol codes.
    localparam int unsigned        HEADER_BYTES       = 20;
    localparam logic [WORD_W-1:0]  BINDING_SUCCESS    = 16'h0101;
    localparam logic [WORD_W-1:0]  XOR_MAPPED_ADDRESS = 16'h0020;
    localparam logic [WORD_W-1:0]  COOKIE_HIGH        = 16'h2112;
    localparam logic [IP_W-1:0]    COOKIE             = 32'h2112A442;
    localparam logic [DATA_W-1:0]  FAMILY_IPV4        = 8'h01;
    localparam logic [WORD_W-1:0]  MIN_XMA_LENGTH     = 16'd8;

    // Parse outcome reported with each datagram.
    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_BAD_TYPE,
        ST_OVERRUN,
        ST_BAD_LENGTH,
        ST_BAD_FAMILY,
        ST_NOT_FOUND
    } t_status;

    // One result transaction.
    typedef struct packed {
        t_status           status;
        logic [IP_W-1:0]   mapped_ip;
        logic [WORD_W-1:0] mapped_port;
    } t_result;

endpackage

### design/stunx_in_if.sv
interface stunx_in_if
    import stunx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/stunx_out_if.sv
interface stunx_out_if
    import stunx_pkg::*;
();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [IP_W-1:0]   mapped_ip;
    logic [WORD_W-1:0] mapped_port;

    modport source (output valid, output status, output mapped_ip, output mapped_port,
                    input ready);
    modport sink   (input valid, input status, input mapped_ip, input mapped_port,
                    output ready);
endinterface

### design/stunx_parser.sv
module stunx_parser
    import stunx_pkg::*;
#(
    parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output t_result           o_result
);

    localparam int unsigned POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_DATAGRAM_BYTES);
    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(HEADER_BYTES - 1);

    // Control state, cleared by reset and at the end of every datagram.
    logic [POS_W-1:0]  r_pos,         n_pos,         u_pos;
    logic [POS_W-1:0]  r_attr_offset, n_attr_offset, u_attr_offset;
    logic              r_decided,     n_decided,     u_decided;
    t_status           r_status,      n_status,      u_status;

    // Captured fields; each is written before it is read within a datagram.
    logic [WORD_W-1:0] r_msg_type,    u_msg_type;
    logic [WORD_W-1:0] r_attr_type,   u_attr_type;
    logic [WORD_W-1:0] r_attr_length, u_attr_length;
    logic [DATA_W-1:0] r_family,      u_family;
    logic [WORD_W-1:0] r_xport,       u_xport;
    logic [IP_W-1:0]   r_xip,         u_xip;

    logic [POS_W-1:0]    rel;
    logic [POS_W-1:0]    rel_eff;
    logic [POS_W-1:0]    val_idx;
    logic [PADLEN_W-1:0] attr_end;
    logic [POS_W-1:0]    size;
    logic [POS_W-1:0]    last_pos;
    logic [POS_W-1:0]    tail_rel;
    t_status             final_status;

    // Per-byte update of the parse state.
    always_comb begin
        u_pos         = r_pos;
        u_attr_offset = r_attr_offset;
        u_decided     = r_decided;
        u_status      = r_status;
        u_msg_type    = r_msg_type;
        u_attr_type   = r_attr_type;
        u_attr_length = r_attr_length;
        u_family      = r_family;
        u_xport       = r_xport;
        u_xip         = r_xip;
        rel      = r_pos - r_attr_offset;
        rel_eff  = rel;
        val_idx  = rel - POS_W'(4);
        attr_end = PADLEN_W'(4)
                 + ((PADLEN_W'(r_attr_length) + PADLEN_W'(3)) & ~PADLEN_W'(3));

        if (r_pos < POS_MAX) begin
            u_pos = r_pos + POS_W'(1);
            if (r_pos < POS_HDR) begin
                // Message header: type in the first two bytes, checked on the last.
                if (r_pos == '0) begin
                    u_msg_type = {i_data_byte, r_msg_type[DATA_W-1:0]};
                end else if (r_pos == POS_W'(1)) begin
                    u_msg_type = {r_msg_type[WORD_W-1:DATA_W], i_data_byte};
                end else if (r_pos == POS_TYPE) begin
                    if (r_msg_type != BINDING_SUCCESS) begin
                        u_decided = 1'b1;
                        u_status  = ST_BAD_TYPE;
                    end else begin
                        u_attr_offset = POS_HDR;
                    end
                end
            end else if (!r_decided) begin
                // Step to the next attribute once the padded value has passed.
                if (rel >= POS_W'(4) && PADLEN_W'(rel) == attr_end) begin
                    u_attr_offset = r_pos;
                    rel_eff       = '0;
                end
                val_idx = rel_eff - POS_W'(4);

                if (rel_eff == '0) begin
                    u_attr_type = {i_data_byte, r_attr_type[DATA_W-1:0]};
                end else if (rel_eff == POS_W'(1)) begin
                    u_attr_type = {r_attr_type[WORD_W-1:DATA_W], i_data_byte};
                end else if (rel_eff == POS_W'(2)) begin
                    u_attr_length = {i_data_byte, r_attr_length[DATA_W-1:0]};
                end else if (rel_eff == POS_W'(3)) begin
                    u_attr_length = {r_attr_length[WORD_W-1:DATA_W], i_data_byte};
                    if (r_attr_type == XOR_MAPPED_ADDRESS && u_attr_length == '0) begin
                        u_decided = 1'b1;
                        u_status  = ST_BAD_LENGTH;
                    end
                end else if (WORD_W'(val_idx) < r_attr_length
                             && r_attr_type == XOR_MAPPED_ADDRESS) begin
                    // Value bytes of the address attribute.
                    if (val_idx == POS_W'(1)) begin
                        u_family = i_data_byte;
                    end else if (val_idx == POS_W'(2)) begin
                        u_xport = {i_data_byte, r_xport[DATA_W-1:0]};
                    end else if (val_idx == POS_W'(3)) begin
                        u_xport = {r_xport[WORD_W-1:DATA_W], i_data_byte};
                    end else if (val_idx >= POS_W'(4) && val_idx <= POS_W'(7)) begin
                        u_xip = {r_xip[IP_W-DATA_W-1:0], i_data_byte};
                    end

                    if (WORD_W'(val_idx) == r_attr_length - WORD_W'(1)) begin
                        u_decided = 1'b1;
                        if (r_attr_length < MIN_XMA_LENGTH) begin
                            u_status = ST_BAD_LENGTH;
                        end else if (u_family != FAMILY_IPV4) begin
                            u_status = ST_BAD_FAMILY;
                        end else begin
                            u_status = ST_OK;
                        end
                    end
                end
            end
        end
    end

    // Outcome at the final byte, from the updated state.
    always_comb begin
        size     = u_pos;
        last_pos = size - POS_W'(1);
        tail_rel = last_pos - u_attr_offset;
        if (u_decided) begin
            final_status = u_status;
        end else if (size < POS_HDR) begin
            final_status = ST_SHORT;
        end else if (last_pos < u_attr_offset || last_pos < POS_HDR) begin
            final_status = ST_NOT_FOUND;
        end else if (tail_rel >= POS_W'(3)
                     && WORD_W'(tail_rel - POS_W'(3)) < u_attr_length) begin
            final_status = ST_OVERRUN;
        end else begin
            final_status = ST_NOT_FOUND;
        end

        o_result.status      = final_status;
        o_result.mapped_ip   = (final_status == ST_OK) ? (u_xip ^ COOKIE) : '0;
        o_result.mapped_port = (final_status == ST_OK) ? (u_xport ^ COOKIE_HIGH) : '0;
    end

    // The final byte returns the control state to its reset values.
    always_comb begin
        if (i_last_byte) begin
            n_pos         = '0;
            n_attr_offset = '0;
            n_decided     = 1'b0;
            n_status      = ST_OK;
        end else begin
            n_pos         = u_pos;
            n_attr_offset = u_attr_offset;
            n_decided     = u_decided;
            n_status      = u_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_attr_offset <= '0;
            r_decided     <= 1'b0;
            r_status      <= ST_OK;
        end else if (i_step) begin
            r_pos         <= n_pos;
            r_attr_offset <= n_attr_offset;
            r_decided     <= n_decided;
            r_status      <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_msg_type    <= u_msg_type;
            r_attr_type   <= u_attr_type;
            r_attr_length <= u_attr_length;
            r_family      <= u_family;
            r_xport       <= u_xport;
            r_xip         <= u_xip;
        end
    end

endmodule

### design/stun_xor_mapped_address_parser_core.sv
// The final byte is held in the input register; its result then goes to the output register.
// Throughput: one datagram byte per cycle; the block stalls only when a finished
// result sits unclaimed in the output register and another final byte arrives.
// Reset: synchronous, active low; clears the input and output valid flags and the
// parse position, so the next byte is taken as the first byte of a datagram.
module stun_xor_mapped_address_parser_core
    import stunx_pkg::*;
#(
    parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stunx_in_if.sink    i_in,
    stunx_out_if.source o_out
);

    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_result           parse_result;
    logic              step;

    // A byte moves on unless it is a final byte and the output register is held.
    assign step       = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    stunx_parser #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (parse_result)
    );

    // Output register holding one result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.mapped_ip   = r_out.mapped_ip;
    assign o_out.mapped_port = r_out.mapped_port;

endmodule
